// File: design/row_convolve_reflect_unit_assert.svh
// Assertion macros for the row convolution unit.
`ifndef ROW_CONVOLVE_REFLECT_UNIT_ASSERT_SVH
`define ROW_CONVOLVE_REFLECT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define RCR_ASSERT_HOLDS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("row_convolve_reflect_unit: invariant violated");

`define RCR_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("row_convolve_reflect_unit: implication violated");

`else

`define RCR_ASSERT_HOLDS(lbl, ck, rn, expr)

`define RCR_ASSERT_IMPLY(lbl, ck, rn, ante, cons)

`endif

`endif

// File: design/rcr_pkg.sv
package rcr_pkg;

  localparam int MAX_TAPS     = 15;
  localparam int ROW_MAX      = 2048;
  localparam int CHANNEL_BITS = 16;

  localparam int TAP_W        = 16;
  localparam int TAP_FRAC     = 14;
  localparam int TAP_IDX_W    = 4;
  localparam int TAP_CNT_CFG_W = 4;
  localparam int ROW_LEN_CFG_W = 12;
  localparam int MARK_W       = 4;
  localparam int COL_W        = 11;
  localparam int RESULT_LIMIT = 8;

  localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAPC_W   = $clog2(MAX_TAPS + 1);
  localparam int ROW_AW   = $clog2(ROW_MAX);
  localparam int CNT_W    = $clog2(ROW_MAX + 1);
  localparam int RES_CW   = $clog2(RESULT_LIMIT + 1);
  localparam int ENTRY_W  = 3 * CHANNEL_BITS + MARK_W;
  localparam int PROD_W   = TAP_W + CHANNEL_BITS + 1;
  localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int RND_HALF = 1 << (TAP_FRAC - 1);
  localparam int CH_MAX   = (1 << CHANNEL_BITS) - 1;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = ROW_LEN_CFG_W;
  localparam logic [CFG_IW-1:0] CFG_TAP_COUNT  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_ROW_LENGTH = CFG_IW'(1);

  localparam logic OP_LOAD_TAP = 1'b0;
  localparam logic OP_PIXEL    = 1'b1;

  // input beat layout
  localparam int IN_TIDX_LO = 0;
  localparam int IN_TVAL_LO = IN_TIDX_LO + TAP_IDX_W;
  localparam int IN_RED_LO  = IN_TVAL_LO + TAP_W;
  localparam int IN_GRN_LO  = IN_RED_LO + CHANNEL_BITS;
  localparam int IN_BLU_LO  = IN_GRN_LO + CHANNEL_BITS;
  localparam int IN_INV_LO  = IN_BLU_LO + CHANNEL_BITS;
  localparam int IN_BITS    = IN_INV_LO + MARK_W;
  localparam int IN_DW      = ((IN_BITS + 7) / 8) * 8;

  // output beat layout
  localparam int OUT_COL_LO = 0;
  localparam int OUT_RED_LO = OUT_COL_LO + COL_W;
  localparam int OUT_GRN_LO = OUT_RED_LO + CHANNEL_BITS;
  localparam int OUT_BLU_LO = OUT_GRN_LO + CHANNEL_BITS;
  localparam int OUT_INV_LO = OUT_BLU_LO + CHANNEL_BITS;
  localparam int OUT_BITS   = OUT_INV_LO + MARK_W;
  localparam int OUT_DW     = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_UW     = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] value;
    logic                    sat;
  } rnd_t;

  function automatic rnd_t round_clamp(input logic signed [ACC_W-1:0] sum);
    logic signed [ACC_W:0] t;
    logic [ACC_W:0]        r;
    rnd_t                  res;
    t = $signed({sum[ACC_W-1], sum}) + $signed((ACC_W + 1)'(RND_HALF));
    r = $unsigned(t) >> TAP_FRAC;
    if (t[ACC_W]) begin
      res.value = '0;
      res.sat   = 1'b1;
    end else if (r > (ACC_W + 1)'(CH_MAX)) begin
      res.value = '1;
      res.sat   = 1'b1;
    end else begin
      res.value = r[CHANNEL_BITS-1:0];
      res.sat   = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: design/row_convolve_reflect_unit.sv
// Horizontal FIR over RGB pixel rows with mirrored edges.
// in_*  : one beat is either a tap load (in_tuser = 0) or a pixel (in_tuser = 1).
//         A tap load is taken while idle, leaves the block idle and gives no result.
// out_* : filtered columns in order; out_tlast marks the final result of the
//         input beat, out_tuser[1] the last column of the row.
// cfg_* : tap count (index 0) and row length (index 1), written while idle.
// A pixel beat writes the row memory, then each ready column is computed by
// walking the taps through the row memory: one read a cycle feeding one
// multiply-accumulate per channel. A column takes a check, one or more
// mirror-reduction steps, one read per tap (one with no taps), a drain of the
// read, product and accumulate registers and a result step; a pixel beat
// releases at most 8 columns.
// Results leave through an output register; the next column waits only while
// that register is still full, and a new input beat is taken once the columns
// of the current one are out of the datapath, even if the last result is
// still held. Reset clears the taps, the counters and the output valid flag;
// the row memory is not cleared and is only ever read where written.
`include "row_convolve_reflect_unit_assert.svh"

module row_convolve_reflect_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tap_index, tap_value, in_red, in_green, in_blue, in_invalid
  input  logic [rcr_pkg::IN_DW-1:0]   in_tdata,
  // opcode
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_column, out_red, out_green, out_blue, out_invalid, zero fill
  output logic [rcr_pkg::OUT_DW-1:0]  out_tdata,
  // saturated, row_done
  output logic [rcr_pkg::OUT_UW-1:0]  out_tuser,
  // last_of_run
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic [rcr_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rcr_pkg::CFG_DW-1:0]  cfg_wdata
);

  rcr_pkg::state_t state_r, state_nxt;

  logic [rcr_pkg::TAP_CNT_CFG_W-1:0] tap_count_r;
  logic [rcr_pkg::ROW_LEN_CFG_W-1:0] row_len_r;
  logic signed [rcr_pkg::TAP_W-1:0]  tap_store_r [rcr_pkg::MAX_TAPS];

  logic [rcr_pkg::CNT_W-1:0]  pr_r, nc_r;
  logic [rcr_pkg::RES_CW-1:0] cnt_r;
  logic [rcr_pkg::CNT_W:0]    start_r;
  logic [rcr_pkg::ROW_AW-1:0] p_r;
  logic                       up_r;
  logic [rcr_pkg::TAP_AW-1:0] kiss_r, k1_r;
  logic                       v1_r, v2_r;

  logic [rcr_pkg::ENTRY_W-1:0] mem [rcr_pkg::ROW_MAX];
  logic [rcr_pkg::ENTRY_W-1:0] rd_data_r;

  logic signed [rcr_pkg::PROD_W-1:0] prod_r [3];
  logic signed [rcr_pkg::ACC_W-1:0]  acc_r  [3];
  logic [rcr_pkg::MARK_W-1:0]        marks_r;

  logic                     out_valid_r;
  logic [rcr_pkg::OUT_DW-1:0] out_data_r;
  logic [rcr_pkg::OUT_UW-1:0] out_user_r;
  logic                     out_last_r;

  // effective configuration
  logic [rcr_pkg::TAPC_W-1:0] taps_eff, off;
  logic [rcr_pkg::CNT_W-1:0]  n_eff, n_m1;
  logic [rcr_pkg::CNT_W:0]    two_n;
  logic [rcr_pkg::ROW_AW-1:0] p_last;
  logic [rcr_pkg::TAP_AW-1:0] k_last;

  always_comb begin
    if (int'(tap_count_r) > rcr_pkg::MAX_TAPS) begin
      taps_eff = rcr_pkg::TAPC_W'(rcr_pkg::MAX_TAPS);
    end else begin
      taps_eff = rcr_pkg::TAPC_W'(tap_count_r);
    end
    off = taps_eff >> 1;
    if (row_len_r == '0) begin
      n_eff = rcr_pkg::CNT_W'(1);
    end else if (int'(row_len_r) > rcr_pkg::ROW_MAX) begin
      n_eff = rcr_pkg::CNT_W'(rcr_pkg::ROW_MAX);
    end else begin
      n_eff = rcr_pkg::CNT_W'(row_len_r);
    end
    n_m1   = n_eff - rcr_pkg::CNT_W'(1);
    two_n  = {n_eff, 1'b0};
    p_last = n_m1[rcr_pkg::ROW_AW-1:0];
    if (taps_eff == '0) begin
      k_last = '0;
    end else begin
      k_last = rcr_pkg::TAP_AW'(taps_eff - rcr_pkg::TAPC_W'(1));
    end
  end

  // input beat fields
  logic                          in_op;
  logic [rcr_pkg::TAP_IDX_W-1:0] in_tidx;
  logic [rcr_pkg::TAP_W-1:0]     in_tval;
  logic [rcr_pkg::ENTRY_W-1:0]   in_entry;
  logic                          in_acc;

  assign in_op    = in_tuser;
  assign in_tidx  = in_tdata[rcr_pkg::IN_TIDX_LO +: rcr_pkg::TAP_IDX_W];
  assign in_tval  = in_tdata[rcr_pkg::IN_TVAL_LO +: rcr_pkg::TAP_W];
  assign in_entry = {in_tdata[rcr_pkg::IN_INV_LO +: rcr_pkg::MARK_W],
                     in_tdata[rcr_pkg::IN_BLU_LO +: rcr_pkg::CHANNEL_BITS],
                     in_tdata[rcr_pkg::IN_GRN_LO +: rcr_pkg::CHANNEL_BITS],
                     in_tdata[rcr_pkg::IN_RED_LO +: rcr_pkg::CHANNEL_BITS]};
  assign in_acc   = in_tvalid && in_tready;

  // pixel accept: abandon a finished or shrunk row first
  logic [rcr_pkg::CNT_W-1:0] pr_eff;
  logic                      row_reset;
  logic                      mem_we;

  assign row_reset = (nc_r >= n_eff);
  assign pr_eff    = row_reset ? '0 : pr_r;
  assign mem_we    = in_acc && (in_op == rcr_pkg::OP_PIXEL) && (pr_eff < n_eff);

  // column readiness
  logic [rcr_pkg::CNT_W:0] need_raw, need1_raw, start_val;
  logic [rcr_pkg::CNT_W:0] need_c, need1_c;
  logic [rcr_pkg::CNT_W-1:0] nc_inc;
  logic col_ready, last_run, out_free;

  always_comb begin
    nc_inc    = nc_r + rcr_pkg::CNT_W'(1);
    start_val = {1'b0, nc_r} + (rcr_pkg::CNT_W + 1)'(off);
    need_raw  = start_val;
    need1_raw = {1'b0, nc_inc} + (rcr_pkg::CNT_W + 1)'(off);
    need_c    = (need_raw > {1'b0, n_m1}) ? {1'b0, n_m1} : need_raw;
    need1_c   = (need1_raw > {1'b0, n_m1}) ? {1'b0, n_m1} : need1_raw;
    col_ready = (int'(cnt_r) < rcr_pkg::RESULT_LIMIT) && (nc_r < n_eff) &&
                ({1'b0, pr_r} > need_c);
    last_run  = (int'(cnt_r) + 1 >= rcr_pkg::RESULT_LIMIT) || (nc_inc >= n_eff) ||
                ({1'b0, pr_r} <= need1_c);
  end

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcr_pkg::ST_IDLE: begin
        if (in_acc && (in_op == rcr_pkg::OP_PIXEL)) begin
          state_nxt = rcr_pkg::ST_CHECK;
        end
      end
      rcr_pkg::ST_CHECK: begin
        state_nxt = col_ready ? rcr_pkg::ST_REDUCE : rcr_pkg::ST_IDLE;
      end
      rcr_pkg::ST_REDUCE: begin
        if (start_r < two_n) begin
          state_nxt = rcr_pkg::ST_MAC;
        end
      end
      rcr_pkg::ST_MAC: begin
        if (kiss_r == k_last) begin
          state_nxt = rcr_pkg::ST_DRAIN;
        end
      end
      rcr_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = rcr_pkg::ST_FINISH;
        end
      end
      rcr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = rcr_pkg::ST_CHECK;
        end
      end
      default: state_nxt = rcr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  logic mem_re, acc_clr, out_load, cnt_clr;

  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    acc_clr   = 1'b0;
    out_load  = 1'b0;
    cnt_clr   = 1'b0;
    case (state_r)
      rcr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cnt_clr   = 1'b1;
      end
      rcr_pkg::ST_CHECK:  acc_clr  = col_ready;
      rcr_pkg::ST_MAC:    mem_re   = 1'b1;
      rcr_pkg::ST_FINISH: out_load = out_free;
      default: begin
      end
    endcase
  end

  // configuration and taps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= rcr_pkg::TAP_CNT_CFG_W'(1);
      row_len_r   <= rcr_pkg::ROW_LEN_CFG_W'(rcr_pkg::ROW_MAX);
      for (int i = 0; i < rcr_pkg::MAX_TAPS; i++) begin
        tap_store_r[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index == rcr_pkg::CFG_TAP_COUNT)) begin
        tap_count_r <= cfg_wdata[rcr_pkg::TAP_CNT_CFG_W-1:0];
      end
      if (cfg_we && (cfg_index == rcr_pkg::CFG_ROW_LENGTH)) begin
        row_len_r <= cfg_wdata[rcr_pkg::ROW_LEN_CFG_W-1:0];
      end
      if (in_acc && (in_op == rcr_pkg::OP_LOAD_TAP) &&
          (int'(in_tidx) < rcr_pkg::MAX_TAPS)) begin
        tap_store_r[rcr_pkg::TAP_AW'(in_tidx)] <= $signed(in_tval);
      end
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pr_eff[rcr_pkg::ROW_AW-1:0]] <= in_entry;
    end
    if (mem_re) begin
      rd_data_r <= mem[p_r];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcr_pkg::ST_IDLE;
      pr_r    <= '0;
      nc_r    <= '0;
      cnt_r   <= '0;
      kiss_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cnt_clr) begin
        cnt_r <= '0;
      end
      if (mem_we) begin
        pr_r <= pr_eff + rcr_pkg::CNT_W'(1);
        nc_r <= row_reset ? '0 : nc_r;
      end else if (in_acc && (in_op == rcr_pkg::OP_PIXEL) && row_reset) begin
        pr_r <= '0;
        nc_r <= '0;
      end
      if ((state_r == rcr_pkg::ST_CHECK) && !col_ready && row_reset) begin
        pr_r <= '0;
        nc_r <= '0;
      end
      if (out_load) begin
        nc_r  <= nc_inc;
        cnt_r <= cnt_r + rcr_pkg::RES_CW'(1);
      end
      if (state_r == rcr_pkg::ST_REDUCE) begin
        kiss_r <= '0;
      end else if (mem_re) begin
        kiss_r <= kiss_r + rcr_pkg::TAP_AW'(1);
      end
      v1_r <= mem_re;
      v2_r <= v1_r;
    end
  end

  // mirror walk: triangle wave over the row
  always_ff @(posedge clk) begin
    if (acc_clr) begin
      start_r <= start_val;
    end
    if (state_r == rcr_pkg::ST_REDUCE) begin
      if (start_r >= two_n) begin
        start_r <= start_r - two_n;
      end else if (start_r < {1'b0, n_eff}) begin
        p_r  <= start_r[rcr_pkg::ROW_AW-1:0];
        up_r <= 1'b0;
      end else begin
        p_r  <= rcr_pkg::ROW_AW'(two_n - (rcr_pkg::CNT_W + 1)'(1) - start_r);
        up_r <= 1'b1;
      end
    end else if (mem_re) begin
      if (up_r) begin
        if (p_r == p_last) begin
          up_r <= 1'b0;
        end else begin
          p_r <= p_r + rcr_pkg::ROW_AW'(1);
        end
      end else begin
        if (p_r == '0) begin
          up_r <= 1'b1;
        end else begin
          p_r <= p_r - rcr_pkg::ROW_AW'(1);
        end
      end
    end
  end

  // multiply-accumulate per channel
  logic signed [rcr_pkg::TAP_W-1:0] tap_k;

  assign tap_k = ({1'b0, k1_r} >= (rcr_pkg::TAP_AW + 1)'(taps_eff)) ? '0 :
                 tap_store_r[k1_r];

  always_ff @(posedge clk) begin
    k1_r <= kiss_r;
    if (v1_r) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= tap_k * $signed({1'b0,
                     rd_data_r[c*rcr_pkg::CHANNEL_BITS +: rcr_pkg::CHANNEL_BITS]});
      end
      if ((rcr_pkg::TAPC_W + rcr_pkg::TAP_AW)'(k1_r) ==
          (rcr_pkg::TAPC_W + rcr_pkg::TAP_AW)'(off)) begin
        marks_r <= rd_data_r[3*rcr_pkg::CHANNEL_BITS +: rcr_pkg::MARK_W];
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (acc_clr) begin
        acc_r[c] <= '0;
      end else if (v2_r) begin
        acc_r[c] <= acc_r[c] + rcr_pkg::ACC_W'(prod_r[c]);
      end
    end
  end

  // result register
  rcr_pkg::rnd_t rnd_r, rnd_g, rnd_b;

  assign rnd_r = rcr_pkg::round_clamp(acc_r[0]);
  assign rnd_g = rcr_pkg::round_clamp(acc_r[1]);
  assign rnd_b = rcr_pkg::round_clamp(acc_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= rcr_pkg::OUT_DW'({marks_r, rnd_b.value, rnd_g.value, rnd_r.value,
                                      rcr_pkg::COL_W'(nc_r)});
      out_user_r <= {(nc_r == n_m1), (rnd_r.sat || rnd_g.sat || rnd_b.sat)};
      out_last_r <= last_run;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `RCR_ASSERT_IMPLY(a_idle_pipe_empty, clk, rst_n, in_tready, !v1_r && !v2_r)
  `RCR_ASSERT_IMPLY(a_read_in_row, clk, rst_n, mem_re, {1'b0, p_r} < n_eff)
  `RCR_ASSERT_HOLDS(a_col_behind_fill, clk, rst_n, nc_r <= pr_r)
  `RCR_ASSERT_IMPLY(a_result_limit, clk, rst_n, out_load,
                    int'(cnt_r) < rcr_pkg::RESULT_LIMIT)

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import rcr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [MARK_W-1:0]       inv;
    logic [CHANNEL_BITS-1:0] blu;
    logic [CHANNEL_BITS-1:0] grn;
    logic [CHANNEL_BITS-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] grn;
    logic [CHANNEL_BITS-1:0] blu;
    logic [MARK_W-1:0]       inv;
    logic                    sat;
    logic                    last;
    logic                    done;
  } column_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic [OUT_UW-1:0]   out_tuser;
  logic                out_tlast;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;

  // mirror of the block's state
  pixel_t                    row_mem [ROW_MAX];
  logic signed [TAP_W-1:0]   tap_coef [MAX_TAPS];
  int                        rx_count;
  int                        col_next;
  logic [TAP_CNT_CFG_W-1:0]  taps_set;
  logic [ROW_LEN_CFG_W-1:0]  len_set;

  column_t pending_columns [$];
  int      mismatches;
  int      columns_checked;
  int      beats_sent;
  int      reg_writes;
  int      cycles;
  logic    steady;

  row_convolve_reflect_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int mirror_col(input int i, input int n);
    int m;
    m = i;
    if (m < 0) m = -m - 1;
    if (m >= n) begin
      m = m % (2 * n);
      if (m >= n) m = 2 * n - m - 1;
    end
    return m;
  endfunction

  // {clamped, value}
  function automatic logic [CHANNEL_BITS:0] fit_channel(input longint acc);
    longint t;
    t = acc + (longint'(1) << (TAP_FRAC - 1));
    if (t < 0) return {1'b1, {CHANNEL_BITS{1'b0}}};
    t = t >>> TAP_FRAC;
    if (t > longint'(CH_MAX)) return {1'b1, {CHANNEL_BITS{1'b1}}};
    return {1'b0, t[CHANNEL_BITS-1:0]};
  endfunction

  function automatic string fmt_col(input column_t c);
    return $sformatf("col %0d r %h g %h b %h inv %h sat %b last %b done %b",
                     c.col, c.red, c.grn, c.blu, c.inv, c.sat, c.last, c.done);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red = CHANNEL_BITS'($urandom);
    p.grn = CHANNEL_BITS'($urandom);
    p.blu = CHANNEL_BITS'($urandom);
    p.inv = MARK_W'($urandom);
    return p;
  endfunction

  // mostly modest taps between -2048 and 6144, sometimes anything
  function automatic logic [TAP_W-1:0] mild_tap();
    if ($urandom_range(0, 99) < 75) return TAP_W'($urandom_range(0, 8192)) - TAP_W'(2048);
    return TAP_W'($urandom);
  endfunction

  task automatic convolve_pixel(input pixel_t px);
    int taps, off, n, j, need, k, idx, emitted, i;
    longint acc_r, acc_g, acc_b, coef;
    logic [CHANNEL_BITS:0] fr, fg, fb;
    column_t res [RESULT_LIMIT];
    taps = int'(taps_set);
    if (taps > MAX_TAPS) taps = MAX_TAPS;
    off = taps / 2;
    n = int'(len_set);
    if (n < 1) n = 1;
    if (n > ROW_MAX) n = ROW_MAX;
    emitted = 0;
    if (col_next >= n) begin
      rx_count = 0;
      col_next = 0;
    end
    if (rx_count < n) begin
      row_mem[rx_count] = px;
      rx_count++;
    end
    while (emitted < RESULT_LIMIT && col_next < n) begin
      j = col_next;
      need = (j + off > n - 1) ? n - 1 : j + off;
      if (rx_count <= need) break;
      acc_r = 0;
      acc_g = 0;
      acc_b = 0;
      for (k = 0; k < taps; k++) begin
        idx = mirror_col(j + off - k, n);
        coef = tap_coef[k];
        acc_r += coef * longint'(row_mem[idx].red);
        acc_g += coef * longint'(row_mem[idx].grn);
        acc_b += coef * longint'(row_mem[idx].blu);
      end
      fr = fit_channel(acc_r);
      fg = fit_channel(acc_g);
      fb = fit_channel(acc_b);
      res[emitted].col  = COL_W'(j);
      res[emitted].red  = fr[CHANNEL_BITS-1:0];
      res[emitted].grn  = fg[CHANNEL_BITS-1:0];
      res[emitted].blu  = fb[CHANNEL_BITS-1:0];
      res[emitted].inv  = row_mem[j].inv;
      res[emitted].sat  = fr[CHANNEL_BITS] | fg[CHANNEL_BITS] | fb[CHANNEL_BITS];
      res[emitted].last = 1'b0;
      res[emitted].done = (j == n - 1);
      emitted++;
      col_next++;
    end
    if (emitted > 0) res[emitted-1].last = 1'b1;
    for (i = 0; i < emitted; i++) pending_columns.push_back(res[i]);
    if (col_next >= n) begin
      rx_count = 0;
      col_next = 0;
    end
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : check_out
    column_t got;
    column_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.col  = out_tdata[OUT_COL_LO +: COL_W];
      got.red  = out_tdata[OUT_RED_LO +: CHANNEL_BITS];
      got.grn  = out_tdata[OUT_GRN_LO +: CHANNEL_BITS];
      got.blu  = out_tdata[OUT_BLU_LO +: CHANNEL_BITS];
      got.inv  = out_tdata[OUT_INV_LO +: MARK_W];
      got.sat  = out_tuser[0];
      got.done = out_tuser[1];
      got.last = out_tlast;
      if (pending_columns.size() == 0) begin
        flag_error({"unexpected beat: ", fmt_col(got)});
      end else begin
        want = pending_columns.pop_front();
        columns_checked++;
        if (got !== want)
          flag_error({"expected ", fmt_col(want), " got ", fmt_col(got)});
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = steady || ($urandom_range(0, 99) >= 17);
    end
  end

  // all stimulus tasks start and end at a falling edge
  task automatic send_beat(input logic op, input logic [TAP_IDX_W-1:0] idx,
                           input logic [TAP_W-1:0] coef, input pixel_t px);
    if (!steady && $urandom_range(0, 99) < 17) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata[IN_TIDX_LO +: TAP_IDX_W]   = idx;
    in_tdata[IN_TVAL_LO +: TAP_W]       = coef;
    in_tdata[IN_RED_LO +: CHANNEL_BITS] = px.red;
    in_tdata[IN_GRN_LO +: CHANNEL_BITS] = px.grn;
    in_tdata[IN_BLU_LO +: CHANNEL_BITS] = px.blu;
    in_tdata[IN_INV_LO +: MARK_W]       = px.inv;
    do @(posedge clk); while (!in_tready);
    if (op == OP_PIXEL) convolve_pixel(px);
    else if (idx < MAX_TAPS) tap_coef[idx] = coef;
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic load_tap(input logic [TAP_IDX_W-1:0] idx, input logic [TAP_W-1:0] coef);
    send_beat(OP_LOAD_TAP, idx, coef, rand_pixel());
  endtask

  task automatic push_pixel(input pixel_t px);
    send_beat(OP_PIXEL, TAP_IDX_W'($urandom), TAP_W'($urandom), px);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (pending_columns.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    settle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_TAP_COUNT) taps_set = val[TAP_CNT_CFG_W-1:0];
    else if (idx == CFG_ROW_LENGTH) len_set = val[ROW_LEN_CFG_W-1:0];
    reg_writes++;
  endtask

  // defaults: one tap of zero, long row
  task automatic test_reset_state();
    push_pixel('{inv: 4'hf, blu: 16'h8000, grn: 16'h0000, red: 16'hffff});
    push_pixel('{inv: 4'h0, blu: 16'h7fff, grn: 16'hffff, red: 16'h0001});
    push_pixel(rand_pixel());
  endtask

  task automatic test_tap_extremes();
    load_tap(4'd0, 16'h7fff);
    load_tap(4'd1, 16'h8000);
    load_tap(4'd14, 16'h4000);
    load_tap(4'd15, 16'h1234);
    // row shrunk below the columns already sent: row is dropped
    write_reg(CFG_ROW_LENGTH, 12'd2);
    push_pixel('{inv: 4'ha, blu: 16'h1234, grn: 16'h0000, red: 16'hffff});
    push_pixel('{inv: 4'h5, blu: 16'hffff, grn: 16'h0100, red: 16'h7fff});
    write_reg(CFG_TAP_COUNT, 12'hff2);
    push_pixel('{inv: 4'h3, blu: 16'h0001, grn: 16'hffff, red: 16'h0000});
    push_pixel('{inv: 4'hc, blu: 16'hffff, grn: 16'h0000, red: 16'h8000});
  endtask

  task automatic test_degenerate_settings();
    write_reg(CFG_TAP_COUNT, 12'd0);
    write_reg(CFG_ROW_LENGTH, 12'd0);
    push_pixel(rand_pixel());
    push_pixel(rand_pixel());
  endtask

  // whole row in, columns still owed: pixel dropped, pending columns flushed
  task automatic test_pending_after_shrink();
    int i;
    write_reg(CFG_TAP_COUNT, 12'd15);
    write_reg(CFG_ROW_LENGTH, 12'd20);
    load_tap(4'd7, 16'h4000);
    for (i = 0; i < 9; i++) push_pixel(rand_pixel());
    write_reg(CFG_ROW_LENGTH, 12'd6);
    push_pixel(rand_pixel());
  endtask

  task automatic test_random_rows();
    int ph, i, taps, len, nload, npix;
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       taps = 15;
        1:       taps = 0;
        default: taps = $urandom_range(0, 15);
      endcase
      case (ph)
        2:       len = 4095;
        3:       len = 2048;
        4:       len = 1;
        default: len = $urandom_range(2, 24);
      endcase
      write_reg(CFG_TAP_COUNT, {8'($urandom), 4'(taps)});
      write_reg(CFG_ROW_LENGTH, CFG_DW'(len));
      steady = (ph == 5);
      nload = $urandom_range(2, 6);
      for (i = 0; i < nload; i++) load_tap(TAP_IDX_W'($urandom_range(0, 14)), mild_tap());
      npix = $urandom_range(6, 14);
      for (i = 0; i < npix; i++) begin
        if ($urandom_range(0, 99) < 8) load_tap(TAP_IDX_W'($urandom), TAP_W'($urandom));
        push_pixel(rand_pixel());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    int i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = OP_LOAD_TAP;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_TAP_COUNT;
    cfg_wdata = '0;
    steady    = 1'b0;
    for (i = 0; i < ROW_MAX; i++) row_mem[i] = '0;
    for (i = 0; i < MAX_TAPS; i++) tap_coef[i] = '0;
    rx_count = 0;
    col_next = 0;
    taps_set = 4'd1;
    len_set  = 12'd2048;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_tap_extremes();
    test_degenerate_settings();
    test_pending_after_shrink();
    test_random_rows();

    settle();
    if (pending_columns.size() != 0)
      flag_error($sformatf("%0d columns never arrived", pending_columns.size()));
    $display("tb: %0d beats in, %0d columns checked, %0d register writes, %0d mismatches",
             beats_sent, columns_checked, reg_writes, mismatches);
    $display("tb: tap counts 0..15, row lengths 1..2048 incl. mid-row shrinks, stalls both sides");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
